// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== hdl/ntpcd_pkg.sv =====
package ntpcd_pkg;

  localparam logic [29:0] NS_PER_SEC    = 30'd1000000000;
  localparam int          DIV_STEPS     = 48;  // 96 quotient bits, 2 per cycle
  localparam logic [8:0]  MIN_PKT_LEN   = 9'd32;
  localparam logic [7:0]  PT_REQUEST    = 8'd210;
  localparam logic [7:0]  PT_RESPONSE   = 8'd211;
  localparam logic [64:0] BIG_ERR_LIMIT = 65'd1099511627;

  typedef enum logic [2:0] {
    ST_REQ_SENT  = 3'd0,
    ST_RESP_SENT = 3'd1,
    ST_SHORT     = 3'd2,
    ST_UNKNOWN   = 3'd3,
    ST_STALE     = 3'd4,
    ST_ADOPTED   = 3'd5,
    ST_SLEWED    = 3'd6
  } status_t;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_SUM  = 11'b000_0000_0010,
    S_DIV  = 11'b000_0000_0100,
    S_PREP = 11'b000_0000_1000,
    S_ADD  = 11'b000_0001_0000,
    S_MAG  = 11'b000_0010_0000,
    S_MUL  = 11'b000_0100_0000,
    S_ACC1 = 11'b000_1000_0000,
    S_ACC2 = 11'b001_0000_0000,
    S_UPD  = 11'b010_0000_0000,
    S_DONE = 11'b100_0000_0000
  } state_t;

endpackage

// ===== hdl/ntpcd_if.sv =====
interface ntpcd_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [62:0] now_ns;
  logic [8:0]  packet_length;
  logic [7:0]  payload_type;
  logic [63:0] originate_stamp;
  logic [63:0] receive_stamp;
  logic [63:0] transmit_stamp;

  modport source (output valid, req_type, now_ns, packet_length, payload_type,
                  originate_stamp, receive_stamp, transmit_stamp, input ready);
  modport sink   (input valid, req_type, now_ns, packet_length, payload_type,
                  originate_stamp, receive_stamp, transmit_stamp, output ready);
endinterface

interface ntpcd_out_if;
  logic               valid;
  logic               ready;
  logic               send_valid;
  logic [7:0]         send_type;
  logic [63:0]        send_originate;
  logic [63:0]        send_receive;
  logic [63:0]        send_transmit;
  logic [2:0]         status;
  logic signed [63:0] clock_offset;
  logic               synced;
  logic               large_error;

  modport source (output valid, send_valid, send_type, send_originate, send_receive,
                  send_transmit, status, clock_offset, synced, large_error,
                  input ready);
  modport sink   (input valid, send_valid, send_type, send_originate, send_receive,
                  send_transmit, status, clock_offset, synced, large_error,
                  output ready);
endinterface

// ===== hdl/ntp_style_clock_discipline_unit.sv =====
// NTP-style clock discipline.
// in_ch (valid/ready): one request tick or one parsed timing packet per transfer,
//   each with the raw local time now_ns. Taken only while the unit is idle.
// out_ch (valid/ready): exactly one result per input transfer, in order: the
//   packet to send (if any), a status code, and offset/synced after the item.
// Every item first forms synced time T = max(0, now_ns + offset) and converts
//   it to 32.32 form with a serial divide by 1e9 at 2 quotient bits a cycle;
//   a short sequence of adds and two multiplies (33x30 and 32x30) then does
//   the adopt or slew arithmetic.
// The unit takes no new item until the previous one has been loaded into the
//   output register.
// A finished result sits in the output register; the unit goes idle and takes
//   the next item while the receiver stalls, and waits at its end only if the
//   previous result has still not been taken.
// Reset (rst_n low, synchronous): offset 0, not synced, no request pending,
//   output empty.
`include "assert_macros.svh"

module ntp_style_clock_discipline_unit (
  input  logic          clk,
  input  logic          rst_n,
  ntpcd_in_if.sink      in_ch,
  ntpcd_out_if.source   out_ch
);

  ntpcd_pkg::state_t  state_r;
  ntpcd_pkg::status_t status_r;

  // latched item
  logic        req_type_r;
  logic [62:0] now_r;
  logic [8:0]  len_r;
  logic [7:0]  ptype_r;
  logic [63:0] t1_r, t2_r, t3_r;

  // discipline state
  logic signed [63:0] offset_r;
  logic               synced_r;
  logic [63:0]        pending_r;

  // working registers
  logic [63:0]        t_r;
  logic [63:0]        a_r, b_r;
  logic [64:0]        s_r;
  logic               neg_r;
  logic [32:0]        mh_r;
  logic [31:0]        ml_r;
  logic               lerr_r;
  logic [62:0]        pa_r;
  logic [61:0]        pb_r;
  logic [63:0]        inner_r;
  logic [63:0]        q_r;

  // output register
  logic               out_vld_r;
  logic               o_send_r;
  logic [7:0]         o_type_r;
  logic [63:0]        o_orig_r, o_recv_r, o_xmit_r;
  logic [2:0]         o_status_r;
  logic signed [63:0] o_offset_r;
  logic               o_synced_r;
  logic               o_lerr_r;

  logic        accept;
  logic        out_load;
  logic [64:0] sum65;
  logic [63:0] ns;
  logic        div_done;
  logic [63:0] div_quot;
  logic [64:0] mag;
  logic [62:0] frac_sum;
  logic        is_send;
  logic        is_resp;

  assign accept   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ntpcd_pkg::S_IDLE);
  assign out_load = (state_r == ntpcd_pkg::S_DONE) && (!out_vld_r || out_ch.ready);

  // synced time, clamped at zero
  assign sum65 = {2'b00, now_r} + {offset_r[63], offset_r};
  assign ns    = sum65[64] ? 64'd0 : sum65[63:0];

  ntpcd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ntpcd_pkg::S_SUM),
    .dividend (ns),
    .done     (div_done),
    .quot     (div_quot)
  );

  assign mag      = s_r[64] ? (~s_r + 65'd1) : s_r;
  assign frac_sum = {27'd0, pa_r[3:0], 32'd0} + {1'b0, pb_r};
  assign is_resp  = (status_r == ntpcd_pkg::ST_RESP_SENT);
  assign is_send  = is_resp || (status_r == ntpcd_pkg::ST_REQ_SENT);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ntpcd_pkg::S_IDLE;
    end else begin
      unique case (state_r)
        ntpcd_pkg::S_IDLE: if (accept) state_r <= ntpcd_pkg::S_SUM;
        ntpcd_pkg::S_SUM:  state_r <= ntpcd_pkg::S_DIV;
        ntpcd_pkg::S_DIV:  if (div_done) state_r <= ntpcd_pkg::S_PREP;
        ntpcd_pkg::S_PREP: state_r <= ntpcd_pkg::S_ADD;
        ntpcd_pkg::S_ADD:  state_r <= ntpcd_pkg::S_MAG;
        ntpcd_pkg::S_MAG:  state_r <= ntpcd_pkg::S_MUL;
        ntpcd_pkg::S_MUL:  state_r <= ntpcd_pkg::S_ACC1;
        ntpcd_pkg::S_ACC1: state_r <= ntpcd_pkg::S_ACC2;
        ntpcd_pkg::S_ACC2: state_r <= ntpcd_pkg::S_UPD;
        ntpcd_pkg::S_UPD:  state_r <= ntpcd_pkg::S_DONE;
        ntpcd_pkg::S_DONE: if (out_load) state_r <= ntpcd_pkg::S_IDLE;
        default:           state_r <= ntpcd_pkg::S_IDLE;
      endcase
    end
  end

  // discipline state updates, committed once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r  <= '0;
      synced_r  <= 1'b0;
      pending_r <= '0;
    end else if (state_r == ntpcd_pkg::S_UPD) begin
      case (status_r)
        ntpcd_pkg::ST_REQ_SENT: pending_r <= t_r;
        ntpcd_pkg::ST_ADOPTED: begin
          offset_r  <= q_r - {1'b0, now_r};
          synced_r  <= 1'b1;
          pending_r <= '0;
        end
        ntpcd_pkg::ST_SLEWED: begin
          offset_r  <= neg_r ? offset_r - q_r : offset_r + q_r;
          pending_r <= '0;
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_r <= in_ch.req_type;
      now_r      <= in_ch.now_ns;
      len_r      <= in_ch.packet_length;
      ptype_r    <= in_ch.payload_type;
      t1_r       <= in_ch.originate_stamp;
      t2_r       <= in_ch.receive_stamp;
      t3_r       <= in_ch.transmit_stamp;
    end
    if (state_r == ntpcd_pkg::S_DIV && div_done) t_r <= div_quot;
    if (state_r == ntpcd_pkg::S_PREP) begin
      a_r <= t2_r - t1_r;
      b_r <= t3_r - t_r;
      if (!req_type_r)                             status_r <= ntpcd_pkg::ST_REQ_SENT;
      else if (len_r < ntpcd_pkg::MIN_PKT_LEN)     status_r <= ntpcd_pkg::ST_SHORT;
      else if (ptype_r == ntpcd_pkg::PT_REQUEST)   status_r <= ntpcd_pkg::ST_RESP_SENT;
      else if (ptype_r != ntpcd_pkg::PT_RESPONSE)  status_r <= ntpcd_pkg::ST_UNKNOWN;
      else if (pending_r == '0 || t1_r != pending_r) status_r <= ntpcd_pkg::ST_STALE;
      else if (!synced_r)                          status_r <= ntpcd_pkg::ST_ADOPTED;
      else                                         status_r <= ntpcd_pkg::ST_SLEWED;
    end
    if (state_r == ntpcd_pkg::S_ADD) s_r <= {a_r[63], a_r} + {b_r[63], b_r};
    if (state_r == ntpcd_pkg::S_MAG) begin
      neg_r  <= s_r[64];
      lerr_r <= mag > ntpcd_pkg::BIG_ERR_LIMIT;
      if (status_r == ntpcd_pkg::ST_ADOPTED) begin
        mh_r <= {1'b0, t3_r[63:32]};
        ml_r <= t3_r[31:0];
      end else begin
        mh_r <= mag[64:32];
        ml_r <= mag[31:0];
      end
    end
    if (state_r == ntpcd_pkg::S_MUL) begin
      pa_r <= 63'({30'd0, mh_r} * {33'd0, ntpcd_pkg::NS_PER_SEC});
      pb_r <= 62'({30'd0, ml_r} * {32'd0, ntpcd_pkg::NS_PER_SEC});
    end
    if (state_r == ntpcd_pkg::S_ACC1) begin
      // adopt: fraction part of ns; slew: low partial of S*1e9 >> 36
      inner_r <= (status_r == ntpcd_pkg::ST_ADOPTED) ? {34'd0, pb_r[61:32]}
                                                     : {37'd0, frac_sum[62:36]};
    end
    if (state_r == ntpcd_pkg::S_ACC2) begin
      q_r <= (status_r == ntpcd_pkg::ST_ADOPTED) ? {1'b0, pa_r} + inner_r
                                                 : {5'd0, pa_r[62:4]} + inner_r;
    end
    if (out_load) begin
      o_send_r   <= is_send;
      o_type_r   <= is_resp ? ntpcd_pkg::PT_RESPONSE
                  : (is_send ? ntpcd_pkg::PT_REQUEST : 8'd0);
      o_orig_r   <= is_resp ? t3_r : 64'd0;
      o_recv_r   <= is_resp ? t_r : 64'd0;
      o_xmit_r   <= is_send ? t_r : 64'd0;
      o_status_r <= status_r;
      o_offset_r <= offset_r;
      o_synced_r <= synced_r;
      o_lerr_r   <= (status_r == ntpcd_pkg::ST_SLEWED) && lerr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.send_valid     = o_send_r;
  assign out_ch.send_type      = o_type_r;
  assign out_ch.send_originate = o_orig_r;
  assign out_ch.send_receive   = o_recv_r;
  assign out_ch.send_transmit  = o_xmit_r;
  assign out_ch.status         = o_status_r;
  assign out_ch.clock_offset   = o_offset_r;
  assign out_ch.synced         = o_synced_r;
  assign out_ch.large_error    = o_lerr_r;

  `ASSERT_IMPL(a_done_in_div, clk, rst_n, div_done, state_r == ntpcd_pkg::S_DIV)
  `ASSERT_NEXT(a_accept_starts, clk, rst_n, accept, state_r == ntpcd_pkg::S_SUM)
  `ASSERT_NEXT(a_synced_sticky, clk, rst_n, synced_r, synced_r)
  `ASSERT_IMPL(a_lerr_on_slew, clk, rst_n, out_vld_r && o_lerr_r,
               o_status_r == ntpcd_pkg::ST_SLEWED)

endmodule

// ===== hdl/ntpcd_div.sv =====
// Radix-4 restoring divide by 1e9 of {dividend, 32'b0}; keeps low 64 quotient
// bits, which is the 32.32 stamp (seconds wrap to 32 bits).
module ntpcd_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  output logic        done,
  output logic [63:0] quot
);

  localparam int CW = $clog2(ntpcd_pkg::DIV_STEPS);

  logic [63:0]   dvd_r;
  logic [29:0]   rem_r;
  logic [63:0]   quo_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [30:0] r1, r1s, r2, r2s;
  logic        ge1, ge2;

  always_comb begin
    r1  = {rem_r, dvd_r[63]};
    ge1 = r1 >= {1'b0, ntpcd_pkg::NS_PER_SEC};
    r1s = ge1 ? r1 - {1'b0, ntpcd_pkg::NS_PER_SEC} : r1;
    r2  = {r1s[29:0], dvd_r[62]};
    ge2 = r2 >= {1'b0, ntpcd_pkg::NS_PER_SEC};
    r2s = ge2 ? r2 - {1'b0, ntpcd_pkg::NS_PER_SEC} : r2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(ntpcd_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[61:0], 2'b00};
      rem_r <= r2s[29:0];
      quo_r <= {quo_r[61:0], ge1, ge2};
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule
